// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk and muted during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");

`endif

// ===== rtl/rwp_pkg.sv =====
// ----------------------------------------------------------------------------
// rwp_pkg
// Constants and codes shared by the RIFF/WAVE PCM16 parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rwp_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned HALF_W = 16;
  localparam int unsigned SPC_W  = 31;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned ERR_W  = 3;

  localparam logic [WORD_W-1:0] TAG_RIFF = 32'h46464952;
  localparam logic [WORD_W-1:0] TAG_WAVE = 32'h45564157;
  localparam logic [WORD_W-1:0] TAG_FMT  = 32'h20746D66;
  localparam logic [WORD_W-1:0] TAG_DATA = 32'h61746164;

  localparam logic [HALF_W-1:0] PCM_FORMAT = 16'd1;
  localparam logic [HALF_W-1:0] PCM_BITS   = 16'd16;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FORMAT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_BAD_RIFF  = 3'd0;
  localparam logic [ERR_W-1:0] ERR_BAD_WAVE  = 3'd1;
  localparam logic [ERR_W-1:0] ERR_NOT_PCM   = 3'd2;
  localparam logic [ERR_W-1:0] ERR_NOT_16BIT = 3'd3;
  localparam logic [ERR_W-1:0] ERR_NO_FMT    = 3'd4;
  localparam logic [ERR_W-1:0] ERR_ZERO_CH   = 3'd5;
  localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;

  // fmt chunk field steps (byte index of the last byte of each field).
  localparam logic [3:0] FMT_STEP_FORMAT = 4'd1;
  localparam logic [3:0] FMT_STEP_CHAN   = 4'd3;
  localparam logic [3:0] FMT_STEP_RATE   = 4'd7;
  localparam logic [3:0] FMT_STEP_BITS   = 4'd15;

endpackage

`default_nettype wire

// ===== rtl/riff_wave_pcm16_parser_unit.sv =====
// ----------------------------------------------------------------------------
// riff_wave_pcm16_parser_unit
// Streaming RIFF/WAVE header walker that emits format info and PCM16 samples.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one file byte per item (in_data_byte), with
//   in_first_byte set on the first byte of each new file, which restarts the
//   parser. The result channel gives at most one item per input item: a
//   sample, the format info at the start of the data chunk, or an error.
//   out_last flags the final item of a file; later bytes are swallowed until
//   the next in_first_byte.
// Sequencing:
//   An ordinary byte's result (if any) is visible in the output register
//   the cycle after it is accepted. The byte that ends the data chunk
//   header starts a restoring divider that computes the samples per
//   channel one quotient bit per cycle; no new byte is taken until the
//   format item is loaded into the output register, as in_ready stays low.
// Stalls and reset:
//   The output register frees the input side: a new byte is taken while a
//   result is being taken in the same cycle. If a result is still waiting
//   and out_ready is low, in_ready drops. Synchronous reset puts the parser
//   back to waiting for the RIFF tag and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module riff_wave_pcm16_parser_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [rwp_pkg::BYTE_W-1:0]          in_data_byte,
  input  wire logic                                in_first_byte,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [rwp_pkg::KIND_W-1:0]               out_kind,
  output logic signed [rwp_pkg::HALF_W-1:0]        out_sample_value,
  output logic [rwp_pkg::HALF_W-1:0]               out_channel_count,
  output logic [rwp_pkg::WORD_W-1:0]               out_sample_rate,
  output logic [rwp_pkg::SPC_W-1:0]                out_samples_per_channel,
  output logic [rwp_pkg::ERR_W-1:0]                out_error_code,
  output logic                                     out_last
);

  import rwp_pkg::*;

  typedef enum logic [3:0] {
    PH_RIFF, PH_RSIZE, PH_WAVE, PH_CID, PH_CSIZE,
    PH_FMT, PH_SKIP, PH_DATA, PH_DONE, PH_HALT
  } parse_phase_t;

  typedef enum logic [1:0] {
    ST_IDLE, ST_DIV, ST_EMIT
  } seq_state_t;

  localparam int unsigned CNT_W = $clog2(SPC_W);
  localparam logic [CNT_W-1:0] DIV_LAST_BIT = CNT_W'(SPC_W - 1);

  // Parser state.
  parse_phase_t      phase_r, phase_nxt;
  logic [1:0]        biw_r, biw_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic [WORD_W-1:0] tag_r, tag_nxt;
  logic [WORD_W-1:0] left_r, left_nxt;
  logic [3:0]        fstep_r, fstep_nxt;
  logic [HALF_W-1:0] kch_r, kch_nxt;
  logic [WORD_W-1:0] krate_r, krate_nxt;
  logic              fseen_r, fseen_nxt;
  logic [BYTE_W-1:0] lowb_r, lowb_nxt;

  // Sequencer and the restoring divider.
  seq_state_t        seq_r;
  logic [SPC_W-1:0]  quo_r;
  logic [HALF_W:0]   rem_r;
  logic [HALF_W-1:0] dvs_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [HALF_W:0]   rem_sh;
  logic              div_ge;

  // Output register.
  logic                     out_valid_r;
  logic [KIND_W-1:0]        out_kind_r;
  logic signed [HALF_W-1:0] out_smp_r;
  logic [HALF_W-1:0]        out_ch_r;
  logic [WORD_W-1:0]        out_rate_r;
  logic [SPC_W-1:0]         out_spc_r;
  logic [ERR_W-1:0]         out_err_r;
  logic                     out_last_r;

  // Result of the byte being accepted.
  logic              res_v;
  logic [KIND_W-1:0] res_kind;
  logic [HALF_W-1:0] res_smp;
  logic [HALF_W-1:0] res_ch;
  logic [WORD_W-1:0] res_rate;
  logic [ERR_W-1:0]  res_err;
  logic              res_last;
  logic              div_go;
  logic [SPC_W-1:0]  div_n;

  logic accept;
  logic slot_free;
  logic load_acc;
  logic load_div;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (seq_r == ST_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;
  assign load_acc  = accept && res_v && !div_go;
  assign load_div  = (seq_r == ST_EMIT) && slot_free;

  // Next parser state for the byte on the input channel.
  always_comb begin
    logic [HALF_W-1:0] half;
    logic [SPC_W-1:0]  n;
    logic [3:0]        s;
    logic              full;
    if (in_first_byte) begin
      phase_nxt = PH_RIFF;
      biw_nxt   = '0;
      word_nxt  = '0;
      tag_nxt   = '0;
      left_nxt  = '0;
      fstep_nxt = '0;
      kch_nxt   = '0;
      krate_nxt = '0;
      fseen_nxt = 1'b0;
      lowb_nxt  = '0;
    end else begin
      phase_nxt = phase_r;
      biw_nxt   = biw_r;
      word_nxt  = word_r;
      tag_nxt   = tag_r;
      left_nxt  = left_r;
      fstep_nxt = fstep_r;
      kch_nxt   = kch_r;
      krate_nxt = krate_r;
      fseen_nxt = fseen_r;
      lowb_nxt  = lowb_r;
    end
    res_v    = 1'b0;
    res_kind = KIND_SAMPLE;
    res_smp  = '0;
    res_ch   = '0;
    res_rate = '0;
    res_err  = ERR_NONE;
    res_last = 1'b0;
    div_go   = 1'b0;
    div_n    = '0;
    half     = '0;
    n        = '0;
    s        = fstep_nxt;
    full     = 1'b0;

    if (phase_nxt != PH_DONE && phase_nxt != PH_HALT) begin
      word_nxt = {in_data_byte, word_nxt[WORD_W-1:BYTE_W]};
      half     = word_nxt[WORD_W-1:HALF_W];
      unique case (phase_nxt)
        PH_RIFF, PH_RSIZE, PH_WAVE, PH_CID, PH_CSIZE: begin
          full    = (biw_nxt == 2'd3);
          biw_nxt = biw_nxt + 2'd1;
          if (full) begin
            unique case (phase_nxt)
              PH_RIFF: begin
                if (word_nxt != TAG_RIFF) begin
                  phase_nxt = PH_HALT;
                  res_v     = 1'b1;
                  res_kind  = KIND_ERROR;
                  res_err   = ERR_BAD_RIFF;
                  res_last  = 1'b1;
                end else begin
                  phase_nxt = PH_RSIZE;
                end
              end
              PH_RSIZE: phase_nxt = PH_WAVE;
              PH_WAVE: begin
                if (word_nxt != TAG_WAVE) begin
                  phase_nxt = PH_HALT;
                  res_v     = 1'b1;
                  res_kind  = KIND_ERROR;
                  res_err   = ERR_BAD_WAVE;
                  res_last  = 1'b1;
                end else begin
                  phase_nxt = PH_CID;
                end
              end
              PH_CID: begin
                tag_nxt   = word_nxt;
                phase_nxt = PH_CSIZE;
              end
              default: begin
                // End of a chunk size word.
                if (tag_nxt == TAG_FMT) begin
                  left_nxt  = word_nxt;
                  fstep_nxt = '0;
                  phase_nxt = PH_FMT;
                end else if (tag_nxt == TAG_DATA) begin
                  n = word_nxt[WORD_W-1:1];
                  if (!fseen_nxt) begin
                    phase_nxt = PH_HALT;
                    res_v     = 1'b1;
                    res_kind  = KIND_ERROR;
                    res_err   = ERR_NO_FMT;
                    res_last  = 1'b1;
                  end else if (kch_nxt == '0) begin
                    phase_nxt = PH_HALT;
                    res_v     = 1'b1;
                    res_kind  = KIND_ERROR;
                    res_err   = ERR_ZERO_CH;
                    res_last  = 1'b1;
                  end else if (n == '0) begin
                    phase_nxt = PH_DONE;
                    res_v     = 1'b1;
                    res_kind  = KIND_FORMAT;
                    res_ch    = kch_nxt;
                    res_rate  = krate_nxt;
                    res_last  = 1'b1;
                  end else begin
                    left_nxt  = {1'b0, n};
                    biw_nxt   = '0;
                    phase_nxt = PH_DATA;
                    res_v     = 1'b1;
                    div_go    = 1'b1;
                    div_n     = n;
                  end
                end else if (word_nxt == '0) begin
                  phase_nxt = PH_CID;
                end else begin
                  left_nxt  = word_nxt;
                  phase_nxt = PH_SKIP;
                end
              end
            endcase
          end
        end
        PH_FMT: begin
          if (left_nxt != '0) begin
            left_nxt = left_nxt - 1'b1;
          end
          fstep_nxt = s + 4'd1;
          if (s == FMT_STEP_FORMAT) begin
            if (half != PCM_FORMAT) begin
              phase_nxt = PH_HALT;
              res_v     = 1'b1;
              res_kind  = KIND_ERROR;
              res_err   = ERR_NOT_PCM;
              res_last  = 1'b1;
            end
          end else if (s == FMT_STEP_CHAN) begin
            kch_nxt = half;
          end else if (s == FMT_STEP_RATE) begin
            krate_nxt = word_nxt;
          end else if (s == FMT_STEP_BITS) begin
            if (half != PCM_BITS) begin
              phase_nxt = PH_HALT;
              res_v     = 1'b1;
              res_kind  = KIND_ERROR;
              res_err   = ERR_NOT_16BIT;
              res_last  = 1'b1;
            end else begin
              fseen_nxt = 1'b1;
              phase_nxt = (left_nxt != '0) ? PH_SKIP : PH_CID;
            end
          end
        end
        PH_SKIP: begin
          if (left_nxt != '0) begin
            left_nxt = left_nxt - 1'b1;
          end
          if (left_nxt == '0) begin
            phase_nxt = PH_CID;
          end
        end
        PH_DATA: begin
          if (biw_nxt == 2'd0) begin
            lowb_nxt = in_data_byte;
            biw_nxt  = 2'd1;
          end else begin
            biw_nxt = 2'd0;
            if (left_nxt != '0) begin
              left_nxt = left_nxt - 1'b1;
            end
            res_v    = 1'b1;
            res_kind = KIND_SAMPLE;
            res_smp  = {in_data_byte, lowb_nxt};
            res_last = (left_nxt == '0);
            if (left_nxt == '0) begin
              phase_nxt = PH_DONE;
            end
          end
        end
        default: phase_nxt = PH_HALT;
      endcase
    end
  end

  // One restoring division step: shift in a dividend bit, compare, subtract.
  assign rem_sh = {rem_r[HALF_W-1:0], quo_r[SPC_W-1]};
  assign div_ge = (rem_sh >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_RIFF;
      biw_r       <= '0;
      word_r      <= '0;
      tag_r       <= '0;
      left_r      <= '0;
      fstep_r     <= '0;
      kch_r       <= '0;
      krate_r     <= '0;
      fseen_r     <= 1'b0;
      lowb_r      <= '0;
      seq_r       <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        biw_r   <= biw_nxt;
        word_r  <= word_nxt;
        tag_r   <= tag_nxt;
        left_r  <= left_nxt;
        fstep_r <= fstep_nxt;
        kch_r   <= kch_nxt;
        krate_r <= krate_nxt;
        fseen_r <= fseen_nxt;
        lowb_r  <= lowb_nxt;
      end

      unique case (seq_r)
        ST_IDLE: begin
          if (accept && div_go) begin
            quo_r <= div_n;
            rem_r <= '0;
            dvs_r <= kch_nxt;
            cnt_r <= DIV_LAST_BIT;
            seq_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r <= div_ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
          quo_r <= {quo_r[SPC_W-2:0], div_ge};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            seq_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            seq_r <= ST_IDLE;
          end
        end
        default: seq_r <= ST_IDLE;
      endcase

      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (load_acc) begin
        out_valid_r <= 1'b1;
        out_kind_r  <= res_kind;
        out_smp_r   <= res_smp;
        out_ch_r    <= res_ch;
        out_rate_r  <= res_rate;
        out_spc_r   <= '0;
        out_err_r   <= res_err;
        out_last_r  <= res_last;
      end else if (load_div) begin
        // Format item of a non-empty data chunk.
        out_valid_r <= 1'b1;
        out_kind_r  <= KIND_FORMAT;
        out_smp_r   <= '0;
        out_ch_r    <= kch_r;
        out_rate_r  <= krate_r;
        out_spc_r   <= quo_r;
        out_err_r   <= ERR_NONE;
        out_last_r  <= 1'b0;
      end
    end
  end

  assign out_valid               = out_valid_r;
  assign out_kind                = out_kind_r;
  assign out_sample_value        = out_smp_r;
  assign out_channel_count       = out_ch_r;
  assign out_sample_rate         = out_rate_r;
  assign out_samples_per_channel = out_spc_r;
  assign out_error_code          = out_err_r;
  assign out_last                = out_last_r;

  // The input side is closed while the divider owns the block.
  `ASSERT_SAME(a_busy_not_ready, seq_r != ST_IDLE, !in_ready)
  // A data chunk header with samples always starts the divider.
  `ASSERT_NEXT(a_div_start, accept && div_go, seq_r == ST_DIV)
  // The partial remainder stays below the divisor.
  `ASSERT_SAME(a_rem_bound, seq_r == ST_DIV, rem_r < {1'b0, dvs_r})
  // Leaving the divider loads a format item that is not the last one.
  `ASSERT_NEXT(a_emit_format, load_div,
    out_valid && out_kind == KIND_FORMAT && !out_last)

endmodule

`default_nettype wire
